>>> rtl/core/disk_request_scheduler_top_macros.svh
// Assertion macros shared by the disk request scheduler RTL.
`ifndef DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define DRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DRS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DRS_ASSERT(label, clk, rst, prop, msg)
`define DRS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/drs_pkg.sv
// Shared types and constants of the disk request scheduler.
package drs_pkg;

   // Largest number of cylinders the 12-bit head and track fields can address.
   localparam int MAX_CYLINDERS = 4096;

   localparam logic [2:0] POL_FCFS  = 3'd0;
   localparam logic [2:0] POL_SSTF  = 3'd1;
   localparam logic [2:0] POL_SCAN  = 3'd2;
   localparam logic [2:0] POL_LOOK  = 3'd3;
   localparam logic [2:0] POL_CSCAN = 3'd4;
   localparam logic [2:0] POL_CLOOK = 3'd5;

   localparam logic [2:0] ST_QUEUED = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_SERVED = 3'd2;
   localparam logic [2:0] ST_EDGE   = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;

   localparam logic [1:0] REG_POLICY    = 2'd0;
   localparam logic [1:0] REG_CYLINDERS = 2'd1;
   localparam logic [1:0] REG_HEAD      = 2'd2;
   localparam logic [1:0] REG_DIRECTION = 2'd3;

   // Kind of search a scan pass performs.
   typedef enum logic [1:0] {
      SRCH_ALL,     // nearest of all entries (SSTF)
      SRCH_AHEAD,   // nearest entry ahead of the head
      SRCH_EXTREME  // lowest or highest entry
   } srch_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SCAN2,
      S_RESOLVE,
      S_READ,
      S_SHIFT,
      S_MOVE,
      S_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic     load;       // capture the accepted request
      logic     append;     // write track at tail
      logic     scan_start; // clear search result, index to zero
      logic     scan_step;  // compare one entry
      srch_type srch;
      logic     strict_up;
      logic     flip_dir;
      logic     set_dir_scan; // SCAN edge rule for direction
      logic     shift_start;
      logic     shift_step;
      logic     read_pick;
      logic     move_pick;  // move head to picked track
      logic     move_edge;  // move head to edge target
      logic     edge_top;   // edge target is the top edge
      logic     out_load;
      logic [2:0] status;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic func;
      logic full;
      logic empty;
      logic found;
      logic scan_done;
      logic shift_done;
      logic dir_down;
      logic at_top;
      logic at_zero;
      logic [2:0] policy;
   } sts_type;

endpackage

>>> rtl/core/drs_ctrl.sv
// Controller state machine of the disk request scheduler.
`include "disk_request_scheduler_top_macros.svh"
module drs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  drs_pkg::sts_type  sts,
   output drs_pkg::cmd_type  cmd
);
   import drs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      second_ff, second_in; // LOOK second pass after flip
   logic      out_free;

   // The result register can take a new result when it is empty or being read.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   // Next state.
   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) state_in = S_DECIDE;
            second_in = 1'b0;
         end
         S_DECIDE: begin
            if (!sts.func || sts.empty) state_in = S_OUT;
            else if ((sts.policy == POL_CSCAN) &&
                     ((!sts.dir_down && sts.at_top) || (sts.dir_down && sts.at_zero)))
               state_in = S_MOVE;
            else if (sts.policy == POL_SSTF || sts.policy == POL_SCAN ||
                     sts.policy == POL_LOOK || sts.policy == POL_CSCAN ||
                     sts.policy == POL_CLOOK)
               state_in = S_SCAN;
            else state_in = S_SHIFT;
         end
         S_SCAN: if (sts.scan_done) state_in = S_RESOLVE;
         S_SCAN2: if (sts.scan_done) state_in = S_READ;
         S_RESOLVE: begin
            if (sts.found) state_in = S_READ;
            else if (sts.policy == POL_LOOK && !second_ff) begin
               state_in  = S_SCAN;
               second_in = 1'b1;
            end else if (sts.policy == POL_CLOOK) state_in = S_SCAN2;
            else state_in = S_MOVE;
         end
         S_READ:  state_in = S_SHIFT;
         S_SHIFT: if (sts.shift_done) state_in = S_MOVE;
         S_MOVE:  state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (state_ff == S_OUT && out_free) rsp_valid_in = 1'b1;
   end

   // Outputs: edge_ff tracks whether the move is an edge move, and stat_ff
   // holds the outcome decided when the request was decoded.
   logic       edge_ff, edge_in;
   logic [2:0] stat_ff, stat_in;
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff <= 1'b0;
         stat_ff <= ST_QUEUED;
      end else begin
         edge_ff <= edge_in;
         stat_ff <= stat_in;
      end
   end

   always_comb begin
      cmd     = '0;
      cmd.srch = SRCH_AHEAD;
      edge_in = edge_ff;
      stat_in = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid && req_tready;
            edge_in  = 1'b0;
         end
         S_DECIDE: begin
            cmd.append      = !sts.func && !sts.full;
            cmd.scan_start  = 1'b1;
            cmd.set_dir_scan = sts.func && !sts.empty && (sts.policy == POL_SCAN);
            if (!sts.func) stat_in = sts.full ? ST_FULL : ST_QUEUED;
            else if (sts.empty) stat_in = ST_EMPTY;
            else stat_in = ST_SERVED;
            if (sts.func && !sts.empty && sts.policy == POL_CSCAN &&
                ((!sts.dir_down && sts.at_top) || (sts.dir_down && sts.at_zero)))
               edge_in = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.srch      = (sts.policy == POL_SSTF) ? SRCH_ALL : SRCH_AHEAD;
            cmd.strict_up = (sts.policy == POL_LOOK) || (sts.policy == POL_CLOOK);
         end
         S_SCAN2: begin
            cmd.scan_step = 1'b1;
            cmd.srch      = SRCH_EXTREME;
         end
         S_RESOLVE: begin
            cmd.scan_start = 1'b1;
            if (!sts.found) begin
               if (sts.policy == POL_LOOK) begin
                  if (!second_ff) cmd.flip_dir = 1'b1;
                  else edge_in = 1'b1; // cannot happen with a non-empty queue
               end else if (sts.policy != POL_CLOOK) edge_in = 1'b1;
            end
            cmd.scan_start = !sts.found;
         end
         S_READ:  cmd.read_pick = 1'b1;
         S_SHIFT: cmd.shift_step = 1'b1;
         S_MOVE: begin
            cmd.move_pick = !edge_ff;
            cmd.move_edge = edge_ff;
            // CSCAN jump goes opposite; SCAN/CSCAN sweep goes to edge ahead.
            if (sts.policy == POL_CSCAN && ((!sts.dir_down && sts.at_top) ||
                (sts.dir_down && sts.at_zero)))
               cmd.edge_top = sts.dir_down;
            else
               cmd.edge_top = !sts.dir_down;
         end
         S_OUT: begin
            cmd.out_load = out_free;
            cmd.status   = (stat_ff == ST_SERVED && edge_ff) ? ST_EDGE : stat_ff;
         end
         default: ;
      endcase
   end

   `DRS_ASSERT(a_out_holds, clock, reset, (state_ff == S_OUT && !out_free) |=> state_ff == S_OUT,
               "result overwritten while waiting")
   `DRS_ASSERT(a_no_accept_busy, clock, reset, (state_ff != S_IDLE) |-> !req_tready,
               "request accepted while busy")
   `DRS_ASSERT(a_out_sets_valid, clock, reset, (state_ff == S_OUT) |=> rsp_valid_ff,
               "result not raised after output state")
endmodule

>>> rtl/core/drs_dpath.sv
// Datapath of the disk request scheduler: queue memory, search, head and total.
`include "disk_request_scheduler_top_macros.svh"
module drs_dpath #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int TOTAL_WIDTH   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_func,
   input  logic [11:0]          req_track,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [12:0]          csr_data,
   input  drs_pkg::cmd_type     cmd,
   output drs_pkg::sts_type     sts,
   output logic [2:0]           out_status,
   output logic [11:0]          out_head,
   output logic [31:0]          out_total,
   output logic                 out_dir,
   output logic [6:0]           out_pending
);
   import drs_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [12:0] MAXC = 13'(MAX_CYLINDERS);
   localparam logic [TOTAL_WIDTH-1:0] TMAX = '1;

   logic [11:0] mem [QUEUE_DEPTH];
   logic [11:0] rd_ff;

   logic [2:0]  policy_ff;
   logic [12:0] cyl_ff;
   logic [11:0] head_ff, head_in;
   logic        down_ff, down_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [CW-1:0] count_ff, count_in;
   logic        func_ff;
   logic [11:0] track_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic        found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [11:0] bt_ff, bt_in;  // best track
   logic [11:0] bd_ff, bd_in;  // best distance
   logic [11:0] pick_ff;
   logic        rd_ok_ff;
   logic [2:0]  ost_ff;
   logic [11:0] ohead_ff;
   logic [31:0] otot_ff;
   logic        odir_ff;
   logic [6:0]  opend_ff;

   logic [12:0] cyl_eff;
   logic [11:0] top;
   always_comb begin
      cyl_eff = cyl_ff;
      if (cyl_eff == 13'd0) cyl_eff = 13'd1;
      if (cyl_eff > MAXC) cyl_eff = MAXC;
      top = 12'(cyl_eff - 13'd1);
   end

   // Memory: one read address, one write address per cycle.
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [11:0]   wr_data;
   logic [CW-1:0] idx_p1;
   assign idx_p1 = idx_ff + CW'(1);

   always_comb begin
      rd_addr = idx_ff[AW-1:0];
      if (cmd.scan_start || cmd.read_pick) rd_addr = cmd.read_pick ? best_ff : AW'(0);
      if (cmd.shift_step) rd_addr = (idx_p1 < CW'(QUEUE_DEPTH)) ? idx_p1[AW-1:0] : idx_ff[AW-1:0];
      if (cmd.scan_step) rd_addr = (idx_p1 < CW'(QUEUE_DEPTH)) ? idx_p1[AW-1:0] : idx_ff[AW-1:0];
      wr_en   = cmd.append || (cmd.shift_step && rd_ok_ff && (idx_ff < count_ff) &&
                (idx_ff > CW'(best_ff)));
      wr_addr = cmd.append ? count_ff[AW-1:0] : AW'(idx_ff - CW'(1));
      wr_data = cmd.append ? track_ff : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   // Candidate test for one entry.
   logic [11:0] t, dist_t;
   logic        ok, better, in_range;
   always_comb begin
      t = rd_ff;
      dist_t = (t > head_ff) ? t - head_ff : head_ff - t;
      in_range = idx_ff < count_ff;
      unique case (cmd.srch)
         SRCH_ALL:    ok = 1'b1;
         SRCH_AHEAD:  ok = down_ff ? (t <= head_ff)
                                   : (cmd.strict_up ? (t > head_ff) : (t >= head_ff));
         SRCH_EXTREME: ok = 1'b1;
         default:     ok = 1'b0;
      endcase
      if (cmd.srch == SRCH_EXTREME)
         better = !found_ff || (down_ff ? (t > bt_ff) : (t < bt_ff));
      else
         better = !found_ff || (dist_t < bd_ff);
   end

   logic [TOTAL_WIDTH-1:0] dmove;
   logic [11:0] target;
   always_comb begin
      target = cmd.move_edge ? (cmd.edge_top ? top : 12'd0) : pick_ff;
      dmove  = TOTAL_WIDTH'((target > head_ff) ? target - head_ff : head_ff - target);
   end

   always_comb begin
      head_in  = head_ff;
      down_in  = down_ff;
      total_in = total_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bt_in    = bt_ff;
      bd_in    = bd_ff;
      // FCFS serves the oldest entry.
      if (cmd.load) best_in = '0;
      if (csr_write && csr_index == REG_HEAD) begin
         head_in  = csr_data[11:0];
         total_in = '0;
      end
      if (csr_write && csr_index == REG_DIRECTION) down_in = csr_data[0];
      if (cmd.append) count_in = count_ff + CW'(1);
      if (cmd.set_dir_scan) begin
         if (head_ff == top) down_in = 1'b1;
         else if (head_ff == 12'd0) down_in = 1'b0;
      end
      if (cmd.flip_dir) down_in = !down_ff;
      if (cmd.scan_start) begin
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         idx_in = idx_p1;
         if (in_range && ok && better) begin
            found_in = 1'b1;
            best_in  = idx_ff[AW-1:0];
            bt_in    = t;
            bd_in    = dist_t;
         end
      end
      if (cmd.read_pick) idx_in = CW'(best_ff);
      if (cmd.shift_step) idx_in = idx_p1;
      if (cmd.move_pick || cmd.move_edge) begin
         head_in  = target;
         total_in = (total_ff > TMAX - dmove) ? TMAX : total_ff + dmove;
         if (cmd.move_pick) count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FCFS;
         cyl_ff    <= 13'd4096;
         head_ff   <= '0;
         down_ff   <= 1'b0;
         total_ff  <= '0;
         count_ff  <= '0;
         rd_ok_ff  <= 1'b0;
      end else begin
         if (csr_write && csr_index == REG_POLICY)    policy_ff <= csr_data[2:0];
         if (csr_write && csr_index == REG_CYLINDERS) cyl_ff    <= csr_data;
         head_ff  <= head_in;
         down_ff  <= down_in;
         total_ff <= total_in;
         count_ff <= count_in;
         rd_ok_ff <= cmd.read_pick || cmd.shift_step;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bt_ff    <= bt_in;
      bd_ff    <= bd_in;
      if (cmd.load) begin
         func_ff  <= req_func;
         track_ff <= req_track;
      end
      if (cmd.shift_step && idx_ff == CW'(best_ff)) pick_ff <= rd_ff;
      if (cmd.out_load) begin
         ost_ff   <= cmd.status;
         ohead_ff <= head_ff;
         otot_ff  <= 32'(total_ff);
         odir_ff  <= down_ff;
         opend_ff <= 7'(count_ff);
      end
   end

   // FCFS goes directly to the shift with index at entry zero.
   assign sts.func       = func_ff;
   assign sts.full       = count_ff >= CW'(QUEUE_DEPTH);
   assign sts.empty      = count_ff == '0;
   assign sts.found      = found_ff;
   assign sts.scan_done  = idx_p1 >= count_ff;
   assign sts.shift_done = idx_p1 >= count_ff;
   assign sts.dir_down   = down_ff;
   assign sts.at_top     = head_ff == top;
   assign sts.at_zero    = head_ff == 12'd0;
   assign sts.policy     = policy_ff;

   assign out_status  = ost_ff;
   assign out_head    = ohead_ff;
   assign out_total   = otot_ff;
   assign out_dir     = odir_ff;
   assign out_pending = opend_ff;

   `DRS_ASSERT(a_count_range, clock, reset, count_ff <= CW'(QUEUE_DEPTH),
               "queue count beyond depth")
   `DRS_ASSERT(a_no_append_full, clock, reset, cmd.append |-> !sts.full,
               "append into full queue")
   `DRS_ASSERT(a_move_one, clock, reset, !(cmd.move_pick && cmd.move_edge),
               "two head moves at once")
endmodule

>>> rtl/core/disk_request_scheduler_top.sv
// Top level of the disk request scheduler.
//
//  channel  | direction | handshake              | payload
//  req      | in        | req_tvalid/req_tready  | tuser func, tdata track
//  rsp      | out       | rsp_tvalid/rsp_tready  | tuser status, tdata {pending,dir,total,head}
//  csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// An add request, and a step on an empty queue, pass from acceptance through
// the decide and output states back to idle. A step with n queued entries
// scans them once with a single comparator (one entry a cycle), reads the pick
// and shifts the later entries down through the one read and one write port.
// FCFS skips the scan; a LOOK flip rescans, a C-LOOK wrap scans for the extreme.
// Reset is synchronous and empties the queue at once through the fill count.
// A result waiting in the output register holds the next request in its last
// state, so input and output are parted by that one register.
module disk_request_scheduler_top #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int TOTAL_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,  // func [0]
   input  logic [15:0] req_tdata,  // track [11:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,  // status [2:0]
   output logic [55:0] rsp_tdata,  // head_track [11:0], total_moved [43:12],
                                   // direction [44], pending [51:45]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import drs_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [2:0]  o_status;
   logic [11:0] o_head;
   logic [31:0] o_total;
   logic        o_dir;
   logic [6:0]  o_pend;

   // Configuration must be written only while the block is idle; the block itself does not enforce this.
   assign csr_ready = 1'b1;

   drs_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   drs_dpath #(
      .QUEUE_DEPTH(QUEUE_DEPTH), .TOTAL_WIDTH(TOTAL_WIDTH)
   ) u_dpath (
      .clock(clock), .reset(reset),
      .req_func(req_tuser), .req_track(req_tdata[11:0]),
      .csr_write(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .sts(sts),
      .out_status(o_status), .out_head(o_head), .out_total(o_total),
      .out_dir(o_dir), .out_pending(o_pend)
   );

   assign rsp_tuser = o_status;
   assign rsp_tdata = {4'b0000, o_pend, o_dir, o_total, o_head};
endmodule

>>> test/drs_checker.sv
// Scoreboard for the disk request scheduler: predicts every response and compares it.
`timescale 1ns / 100ps

module drs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        req_tuser,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,
   input  logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   output int          outstanding,
   output int          fail_count,
   output int          checked_count,
   output int          full_count,
   output int          edge_count
);
   import drs_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] head_track;
      logic [31:0] total_moved;
      logic        direction;
      logic [6:0]  pending;
   } sched_result_type;

   localparam int QUEUE_LIMIT = 64;

   sched_result_type expected_rsp[$];
   logic [11:0]   track_queue[$];
   logic [2:0]    policy_q;
   logic [12:0]   cylinders_q;
   logic [11:0]   head_q;
   logic          down_q;
   logic [31:0]   moved_q;

   function automatic int unsigned gap(int unsigned a, int unsigned b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic int unsigned top_cylinder();
      int unsigned c;
      c = cylinders_q;
      if (c < 1) c = 1;
      if (c > 4096) c = 4096;
      return c - 1;
   endfunction

   // Nearest queued track in the sweep direction; earliest entry wins ties.
   function automatic int nearest_ahead(bit dn, bit strict_up);
      int best;
      int unsigned bd;
      bit ok;
      best = -1;
      bd = 0;
      for (int i = 0; i < track_queue.size(); i++) begin
         ok = dn ? (track_queue[i] <= head_q)
                 : (strict_up ? track_queue[i] > head_q : track_queue[i] >= head_q);
         if (ok && (best < 0 || gap(track_queue[i], head_q) < bd)) begin
            best = i;
            bd = gap(track_queue[i], head_q);
         end
      end
      return best;
   endfunction

   function automatic int extreme_track(bit highest);
      int best;
      best = 0;
      for (int i = 1; i < track_queue.size(); i++)
         if (highest ? track_queue[i] > track_queue[best]
                     : track_queue[i] < track_queue[best]) best = i;
      return best;
   endfunction

   function automatic void seek_to(logic [11:0] target);
      longint unsigned s;
      s = longint'(moved_q) + gap(target, head_q);
      moved_q = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
      head_q = target;
   endfunction

   function automatic sched_result_type predict_request(logic func, logic [11:0] track);
      sched_result_type r;
      int pick;
      bit is_edge;
      logic [11:0] edge_t;
      int unsigned top;
      top = top_cylinder();
      pick = -1;
      is_edge = 0;
      edge_t = '0;
      if (func == 1'b0) begin
         if (track_queue.size() >= QUEUE_LIMIT) r.status = ST_FULL;
         else begin
            track_queue.insert(track_queue.size(), track);
            r.status = ST_QUEUED;
         end
      end else if (track_queue.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         case (policy_q)
            POL_SSTF: begin
               pick = 0;
               for (int i = 1; i < track_queue.size(); i++)
                  if (gap(track_queue[i], head_q) < gap(track_queue[pick], head_q)) pick = i;
            end
            POL_SCAN: begin
               if (head_q == top) down_q = 1;
               else if (head_q == 0) down_q = 0;
               pick = nearest_ahead(down_q, 0);
               if (pick < 0) begin
                  is_edge = 1;
                  edge_t = down_q ? 12'd0 : top[11:0];
               end
            end
            POL_LOOK: begin
               pick = nearest_ahead(down_q, 1);
               if (pick < 0) begin
                  down_q = ~down_q;
                  pick = nearest_ahead(down_q, 1);
               end
            end
            POL_CSCAN: begin
               if (!down_q && head_q == top) begin
                  is_edge = 1;
                  edge_t = 12'd0;
               end else if (down_q && head_q == 0) begin
                  is_edge = 1;
                  edge_t = top[11:0];
               end else begin
                  pick = nearest_ahead(down_q, 0);
                  if (pick < 0) begin
                     is_edge = 1;
                     edge_t = down_q ? 12'd0 : top[11:0];
                  end
               end
            end
            POL_CLOOK: begin
               pick = nearest_ahead(down_q, 1);
               if (pick < 0) pick = extreme_track(down_q);
            end
            default: pick = 0;
         endcase
         if (is_edge || pick < 0) begin
            seek_to(edge_t);
            r.status = ST_EDGE;
         end else begin
            edge_t = track_queue[pick];
            track_queue.delete(pick);
            seek_to(edge_t);
            r.status = ST_SERVED;
         end
      end
      r.head_track = head_q;
      r.total_moved = moved_q;
      r.direction = down_q;
      r.pending = 7'(track_queue.size());
      return r;
   endfunction

   always @(posedge clock) begin
      sched_result_type got, exp_r;
      if (reset) begin
         expected_rsp.delete();
         track_queue.delete();
         policy_q = POL_FCFS;
         cylinders_q = 13'd4096;
         head_q = '0;
         down_q = 0;
         moved_q = '0;
         fail_count = 0;
         checked_count = 0;
         full_count = 0;
         edge_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_POLICY:    policy_q = csr_data[2:0];
               REG_CYLINDERS: cylinders_q = csr_data;
               REG_HEAD: begin
                  head_q = csr_data[11:0];
                  moved_q = '0;
               end
               REG_DIRECTION: down_q = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_rsp.insert(expected_rsp.size(),
                                predict_request(req_tuser, req_tdata[11:0]));
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser;
            got.head_track  = rsp_tdata[11:0];
            got.total_moved = rsp_tdata[43:12];
            got.direction   = rsp_tdata[44];
            got.pending     = rsp_tdata[51:45];
            if (expected_rsp.size() == 0) begin
               $display("%0t: response %h with nothing expected", $time, got);
               fail_count++;
            end else begin
               exp_r = expected_rsp.pop_front();
               checked_count++;
               if (exp_r.status == ST_FULL) full_count++;
               if (exp_r.status == ST_EDGE) edge_count++;
               if (got.status != exp_r.status) begin
                  $display("%0t: status expected %0d got %0d", $time, exp_r.status, got.status);
                  fail_count++;
               end
               if (got.head_track != exp_r.head_track) begin
                  $display("%0t: head expected %0d got %0d",
                           $time, exp_r.head_track, got.head_track);
                  fail_count++;
               end
               if (got.total_moved != exp_r.total_moved) begin
                  $display("%0t: total expected %0d got %0d",
                           $time, exp_r.total_moved, got.total_moved);
                  fail_count++;
               end
               if (got.direction != exp_r.direction) begin
                  $display("%0t: direction expected %0d got %0d",
                           $time, exp_r.direction, got.direction);
                  fail_count++;
               end
               if (got.pending != exp_r.pending) begin
                  $display("%0t: pending expected %0d got %0d",
                           $time, exp_r.pending, got.pending);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_rsp.size();
   end

endmodule

>>> test/tb_disk_request_scheduler_top.sv
// Testbench top for the disk request scheduler: stimulus, back pressure and verdict.
`timescale 1ns / 100ps

module tb_disk_request_scheduler_top;
   import drs_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic        req_tuser;   // func
   logic [15:0] req_tdata;   // track [11:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;   // status
   logic [55:0] rsp_tdata;   // head_track, total_moved, direction, pending
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   int outstanding;
   int fail_count;
   int checked_count;
   int full_count;
   int edge_count;
   int sent_count;
   int idle_cycles;
   bit long_hold;
   int unsigned cur_top;

   localparam int WATCHDOG_LIMIT = 5000;

   disk_request_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   drs_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .outstanding(outstanding), .fail_count(fail_count),
      .checked_count(checked_count), .full_count(full_count), .edge_count(edge_count)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Response side. Each response draws its own stall, and once in the run the
   // receiver holds off for a long stretch so the block backs up onto the
   // request channel.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Register writes happen only while the block is idle.
   task automatic write_reg(logic [1:0] idx, logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one request after a random gap (none when no_gap is set); returns just after it is accepted.
   task automatic offer_request(logic func, logic [11:0] track, bit no_gap = 0);
      int wait_n;
      wait_n = no_gap ? 0 : $urandom_range(0, 6);
      if (wait_n > 0) begin
         req_tvalid <= 1'b0;
         repeat (wait_n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {4'h0, track};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(logic [2:0] pol, logic [12:0] cyl, logic [11:0] head, logic dn);
      int unsigned c;
      drain_block();
      write_reg(REG_POLICY, {10'd0, pol});
      write_reg(REG_CYLINDERS, cyl);
      write_reg(REG_HEAD, {1'b0, head});
      write_reg(REG_DIRECTION, {12'd0, dn});
      c = cyl == 0 ? 1 : (cyl > 4096 ? 4096 : cyl);
      cur_top = c - 1;
   endtask

   // Tracks mostly fall on the disk, with the edges and off-disk values mixed in.
   function automatic logic [11:0] pick_track();
      case ($urandom_range(0, 7))
         0: return 12'd0;
         1: return cur_top[11:0];
         2: return 12'($urandom_range(0, 4095));
         default: return 12'($urandom_range(0, cur_top));
      endcase
   endfunction

   initial begin
      int steps_pct;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      sent_count = 0;
      long_hold = 0;
      cur_top = 4095;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings (FCFS, full disk): an empty
      // step, adds of both track extremes and two middle tracks, then five steps.
      offer_request(1'b1, 12'd0);
      offer_request(1'b0, 12'd0);
      offer_request(1'b0, 12'hFFF);
      offer_request(1'b0, 12'h555);
      offer_request(1'b0, 12'hAAA);
      repeat (5) offer_request(1'b1, 12'd0);

      // SCAN and C-SCAN with the head parked on each edge, so the edge bounce,
      // wraps and edge sweeps show up.
      set_mode(POL_SCAN, 13'd100, 12'd99, 1'b0);
      offer_request(1'b0, 12'd50);
      offer_request(1'b0, 12'd99);
      repeat (3) offer_request(1'b1, 12'd0);
      set_mode(POL_CSCAN, 13'd100, 12'd99, 1'b0);
      offer_request(1'b0, 12'd20);
      repeat (3) offer_request(1'b1, 12'd0);
      set_mode(POL_CSCAN, 13'd0, 12'd0, 1'b1);
      offer_request(1'b0, 12'd3000);
      repeat (3) offer_request(1'b1, 12'd0);

      // Random phases: every policy code including the unused ones, with
      // cylinder counts at both limits and beyond the upper one.
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: set_mode(ph[2:0] ^ 3'(ph / 8), 13'd4096, 12'($urandom_range(0, 4095)), ph[0]);
            1: set_mode(ph[2:0] ^ 3'(ph / 8), 13'd1, 12'($urandom_range(0, 3)), ph[1]);
            2: set_mode(ph[2:0] ^ 3'(ph / 8), 13'h1FFF, 12'hFFF, 1'b1);
            default: set_mode(ph[2:0] ^ 3'(ph / 8), 13'($urandom_range(2, 300)),
                              12'($urandom_range(0, 299)), 1'($urandom_range(0, 1)));
         endcase
         // Fill the queue past its depth so the full case is reached.
         if (ph == 2 || ph == 9) begin
            for (int i = 0; i < 68; i++) offer_request(1'b0, pick_track(), i > 60);
         end
         if (ph == 5) long_hold = 1;
         steps_pct = $urandom_range(30, 65);
         for (int i = 0; i < 56; i++) begin
            if ($urandom_range(0, 99) < steps_pct)
               offer_request(1'b1, 12'($urandom_range(0, 4095)));
            else
               offer_request(1'b0, pick_track(), $urandom_range(0, 4) == 0);
         end
      end

      drain_block();
      repeat (20) @(posedge clock);

      $display("Sent %0d requests over 16 random phases covering all policy codes,", sent_count);
      $display("%0d responses checked, %0d dropped as full, %0d edge sweeps.",
               checked_count, full_count, edge_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
